// ===== sv/obbpc_pkg.sv =====
// Shared types, widths and register codes for the oriented box point query block.
package obbpc_pkg;

    // Field and register widths
    localparam int unsigned COORD_W  = 16;
    localparam int unsigned REG_W    = 48;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned DIFF_W   = COORD_W + 1;
    localparam int unsigned PROD_W   = DIFF_W + COORD_W;
    localparam int unsigned PROJ_W   = PROD_W + 2;
    localparam int unsigned CLAMP_W  = 30;
    localparam int unsigned TERM_W   = CLAMP_W + COORD_W;
    localparam int unsigned ACC_W    = 48;
    localparam int unsigned PROJ_SH  = 14;
    localparam int unsigned OUT_SH   = 28;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_AXIS_U = 3'd0;
    localparam logic [IDX_W-1:0] REG_AXIS_V = 3'd1;
    localparam logic [IDX_W-1:0] REG_AXIS_W = 3'd2;
    localparam logic [IDX_W-1:0] REG_CENTER = 3'd3;
    localparam logic [IDX_W-1:0] REG_HALF   = 3'd4;

    // Register reset values
    localparam logic [REG_W-1:0] AXIS_U_RST = 48'h0000_0000_4000;
    localparam logic [REG_W-1:0] AXIS_V_RST = 48'h0000_4000_0000;
    localparam logic [REG_W-1:0] AXIS_W_RST = 48'h4000_0000_0000;
    localparam logic [REG_W-1:0] CENTER_RST = 48'h0000_0000_0000;
    localparam logic [REG_W-1:0] HALF_RST   = 48'h0100_0100_0100;

    // Offset of the point from the centre, one entry per coordinate
    typedef logic [2:0][DIFF_W-1:0] diff_vec_t;

    // What one axis lane hands back: its three weighted terms and the range flag
    typedef struct packed {
        logic                     outside;
        logic [2:0][TERM_W-1:0]   term;
    } axis_res_t;

endpackage

// ===== sv/obbpc_axis.sv =====
// One axis lane: projection, range test, clamp and axis-weighted terms.
module obbpc_axis (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [obbpc_pkg::REG_W-1:0]       axis_packed,
    input  logic [obbpc_pkg::COORD_W-1:0]     half_extent,
    input  obbpc_pkg::diff_vec_t              diff,
    output obbpc_pkg::axis_res_t              res
);

    logic signed [obbpc_pkg::COORD_W-1:0] ax [3];
    logic signed [obbpc_pkg::PROD_W-1:0]  prod_reg [3];
    logic signed [obbpc_pkg::PROD_W-1:0]  prod_next [3];
    logic signed [obbpc_pkg::PROJ_W-1:0]  proj_reg;
    logic signed [obbpc_pkg::PROJ_W-1:0]  proj_next;
    logic signed [obbpc_pkg::PROJ_W-1:0]  lim;
    logic signed [obbpc_pkg::CLAMP_W-1:0] clamp_reg;
    logic signed [obbpc_pkg::CLAMP_W-1:0] clamp_next;
    logic                                 out_reg;
    logic                                 out_next;
    logic                                 over;
    logic                                 under;
    logic [2:0][obbpc_pkg::TERM_W-1:0]    term_reg;
    logic [2:0][obbpc_pkg::TERM_W-1:0]    term_next;
    logic                                 outd_reg;
    logic [obbpc_pkg::COORD_W-2:0]        h_pos;

    // Unpack the axis components
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ax[c] = $signed(axis_packed[c*obbpc_pkg::COORD_W +: obbpc_pkg::COORD_W]);
        end
    end

    // Multiply each offset component by its axis component
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod_next[c] = $signed(diff[c]) * ax[c];
        end
    end

    // Sum the three products into the projection
    assign proj_next = obbpc_pkg::PROJ_W'(prod_reg[0]) + obbpc_pkg::PROJ_W'(prod_reg[1])
                     + obbpc_pkg::PROJ_W'(prod_reg[2]);

    // Treat a negative half extent as zero, scale to the projection format
    assign h_pos = half_extent[obbpc_pkg::COORD_W-1] ? '0
                                                      : half_extent[obbpc_pkg::COORD_W-2:0];
    assign lim   = $signed({6'b0, h_pos, {obbpc_pkg::PROJ_SH{1'b0}}});
    assign over  = proj_reg > lim;
    assign under = proj_reg < -lim;

    // Clamp the projection to plus or minus the limit
    always_comb begin
        if (over) begin
            clamp_next = lim[obbpc_pkg::CLAMP_W-1:0];
        end else if (under) begin
            clamp_next = obbpc_pkg::CLAMP_W'(-lim);
        end else begin
            clamp_next = proj_reg[obbpc_pkg::CLAMP_W-1:0];
        end
        out_next = over | under;
    end

    // Weight the clamped projection by each axis component
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            term_next[c] = ax[c] * clamp_reg;
        end
    end

    // Advance the lane stages
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= prod_next;
            proj_reg  <= proj_next;
            clamp_reg <= clamp_next;
            out_reg   <= out_next;
            term_reg  <= term_next;
            outd_reg  <= out_reg;
        end
    end

    assign res.outside = outd_reg;
    assign res.term    = term_reg;

endmodule

// ===== sv/obb_point_containment_closest_unit.sv =====
// Top level of the oriented box point containment and closest point block.
// The s_ channel carries one query point per item (signed Q8.8 x, y, z). The
// m_ channel returns one item per point: an inside flag and the closest point
// on the box, saturated to Q8.8. The box (three Q2.14 axes, a Q8.8 centre and
// three half extents) sits in five registers written through cfg_wr_en,
// cfg_index and cfg_wdata; write them only while no item is in flight.
// Unknown register indexes are ignored.
// The pipeline has six stages from acceptance to a valid result: offset,
// products, projection sum, clamp, weighted terms, final sum with rounding and
// saturation. One item is accepted every cycle while the receiver does not
// stall.
// Reset clears every stage valid and loads the registers with a unit box at
// the origin aligned to x, y, z.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_ready drops; nothing is lost or repeated.
module obb_point_containment_closest_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [obbpc_pkg::IDX_W-1:0]           cfg_index,
    input  logic [obbpc_pkg::REG_W-1:0]           cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [obbpc_pkg::COORD_W-1:0]  s_point_x,
    input  logic signed [obbpc_pkg::COORD_W-1:0]  s_point_y,
    input  logic signed [obbpc_pkg::COORD_W-1:0]  s_point_z,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_inside_res,
    output logic signed [obbpc_pkg::COORD_W-1:0]  m_closest_x,
    output logic signed [obbpc_pkg::COORD_W-1:0]  m_closest_y,
    output logic signed [obbpc_pkg::COORD_W-1:0]  m_closest_z
);

    logic [obbpc_pkg::REG_W-1:0] axis_reg [3];
    logic [obbpc_pkg::REG_W-1:0] center_reg;
    logic [obbpc_pkg::REG_W-1:0] half_reg;

    logic                        en;
    logic [5:0]                  vld_reg;
    logic [5:0]                  vld_next;
    obbpc_pkg::diff_vec_t        diff_reg;
    obbpc_pkg::diff_vec_t        diff_next;
    obbpc_pkg::axis_res_t        lane_res [3];

    logic signed [obbpc_pkg::COORD_W-1:0] pt [3];
    logic signed [obbpc_pkg::COORD_W-1:0] ctr [3];
    logic signed [obbpc_pkg::ACC_W-1:0]   acc [3];
    logic signed [obbpc_pkg::COORD_W-1:0] res_next [3];
    logic signed [obbpc_pkg::COORD_W-1:0] res_reg [3];
    logic                                 inside_next;
    logic                                 inside_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg[0] <= obbpc_pkg::AXIS_U_RST;
            axis_reg[1] <= obbpc_pkg::AXIS_V_RST;
            axis_reg[2] <= obbpc_pkg::AXIS_W_RST;
            center_reg  <= obbpc_pkg::CENTER_RST;
            half_reg    <= obbpc_pkg::HALF_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                obbpc_pkg::REG_AXIS_U: axis_reg[0] <= cfg_wdata;
                obbpc_pkg::REG_AXIS_V: axis_reg[1] <= cfg_wdata;
                obbpc_pkg::REG_AXIS_W: axis_reg[2] <= cfg_wdata;
                obbpc_pkg::REG_CENTER: center_reg  <= cfg_wdata;
                obbpc_pkg::REG_HALF:   half_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance whenever the output register is empty or being taken
    assign en      = !vld_reg[5] || m_ready;
    assign s_ready = en;
    assign vld_next = {vld_reg[4:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // Offset of the point from the centre
    assign pt[0] = s_point_x;
    assign pt[1] = s_point_y;
    assign pt[2] = s_point_z;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ctr[c] = $signed(center_reg[c*obbpc_pkg::COORD_W +: obbpc_pkg::COORD_W]);
            diff_next[c] = obbpc_pkg::DIFF_W'(pt[c]) - obbpc_pkg::DIFF_W'(ctr[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            diff_reg <= diff_next;
        end
    end

    // One lane per box axis
    for (genvar a = 0; a < 3; a++) begin : g_lane
        obbpc_axis u_axis (
            .aclk        (aclk),
            .en          (en),
            .axis_packed (axis_reg[a]),
            .half_extent (half_reg[a*obbpc_pkg::COORD_W +: obbpc_pkg::COORD_W]),
            .diff        (diff_reg),
            .res         (lane_res[a])
        );
    end

    // Sum centre and weighted terms, round half up, saturate
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            acc[c] = obbpc_pkg::ACC_W'($signed({ctr[c], {obbpc_pkg::OUT_SH{1'b0}}}))
                   + obbpc_pkg::ACC_W'($signed(lane_res[0].term[c]))
                   + obbpc_pkg::ACC_W'($signed(lane_res[1].term[c]))
                   + obbpc_pkg::ACC_W'($signed(lane_res[2].term[c]))
                   + obbpc_pkg::ACC_W'(49'sd1 <<< (obbpc_pkg::OUT_SH - 1));
            if (!acc[c][obbpc_pkg::ACC_W-1] &&
                (acc[c][obbpc_pkg::ACC_W-2:obbpc_pkg::OUT_SH+obbpc_pkg::COORD_W-1] != '0)) begin
                res_next[c] = 16'sh7FFF;
            end else if (acc[c][obbpc_pkg::ACC_W-1] &&
                (acc[c][obbpc_pkg::ACC_W-2:obbpc_pkg::OUT_SH+obbpc_pkg::COORD_W-1] != '1)) begin
                res_next[c] = -16'sh8000;
            end else begin
                res_next[c] = $signed(acc[c][obbpc_pkg::OUT_SH +: obbpc_pkg::COORD_W]);
            end
        end
        inside_next = !(lane_res[0].outside || lane_res[1].outside || lane_res[2].outside);
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg    <= res_next;
            inside_reg <= inside_next;
        end
    end

    assign m_valid      = vld_reg[5];
    assign m_inside_res = inside_reg;
    assign m_closest_x  = res_reg[0];
    assign m_closest_y  = res_reg[1];
    assign m_closest_z  = res_reg[2];

endmodule

// ===== sv/obbpc_checker.sv =====
// Port checker for the oriented box point query block, bound to the top level.
module obbpc_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_ready,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic                                  m_inside_res,
    input  logic signed [obbpc_pkg::COORD_W-1:0]  m_closest_x,
    input  logic signed [obbpc_pkg::COORD_W-1:0]  m_closest_y,
    input  logic signed [obbpc_pkg::COORD_W-1:0]  m_closest_z
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // An empty output stage never blocks new items
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no result waiting");

    // The input side stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output back-pressure");

    // A stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_inside_res) && $stable(m_closest_x)
                               && $stable(m_closest_y) && $stable(m_closest_z))
        else $error("stalled result changed");

endmodule

bind obb_point_containment_closest_unit obbpc_checker u_obbpc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_inside_res (m_inside_res),
    .m_closest_x  (m_closest_x),
    .m_closest_y  (m_closest_y),
    .m_closest_z  (m_closest_z)
);

// ===== dv/obb_point_containment_closest_unit_tb.sv =====
// Self-checking testbench for the oriented box point containment and closest point unit.
`timescale 1ns / 100ps

module obb_point_containment_closest_unit_tb;

    import obbpc_pkg::*;

    localparam int          NUM_REGS    = 5;
    localparam int          IDLE_PCT    = 19;
    localparam int          LATENCY_PAD = 10;
    localparam int          PHASE_ITEMS = 315;
    localparam int unsigned CYCLE_LIMIT = 400000;

    // Axis register indexes in u, v, w order
    localparam logic [IDX_W-1:0] AXIS_REG [3] = '{REG_AXIS_U, REG_AXIS_V, REG_AXIS_W};

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic                      in_box;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } box_answer_t;

    logic                      aclk;
    logic                      aresetn      = 1'b0;
    logic                      cfg_wr_en    = 1'b0;
    logic [IDX_W-1:0]          cfg_index    = '0;
    logic [REG_W-1:0]          cfg_wdata    = '0;
    logic                      s_valid      = 1'b0;
    logic                      s_ready;
    logic signed [COORD_W-1:0] s_point_x    = '0;
    logic signed [COORD_W-1:0] s_point_y    = '0;
    logic signed [COORD_W-1:0] s_point_z    = '0;
    logic                      m_valid;
    logic                      m_ready      = 1'b0;
    logic                      m_inside_res;
    logic signed [COORD_W-1:0] m_closest_x;
    logic signed [COORD_W-1:0] m_closest_y;
    logic signed [COORD_W-1:0] m_closest_z;

    // Shadow of the box registers, pending points and answers still owed
    logic [REG_W-1:0] box_reg [NUM_REGS];
    point_t           point_q [$];
    box_answer_t      answer_due_q [$];

    logic        in_taken       = 1'b0;
    logic        steady         = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    obb_point_containment_closest_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_point_x    (s_point_x),
        .s_point_y    (s_point_y),
        .s_point_z    (s_point_z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_inside_res (m_inside_res),
        .m_closest_x  (m_closest_x),
        .m_closest_y  (m_closest_y),
        .m_closest_z  (m_closest_z)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Project the offset onto each axis, test it against the half extent,
    // clamp it and rebuild the nearest point on the box in Q.36
    function automatic box_answer_t query_box(input point_t pt);
        longint             ofs [3];
        longint             acc [3];
        longint             comp [3];
        longint             ctr;
        longint             proj;
        longint             lim;
        longint             rnd;
        logic signed [15:0] coord [3];
        box_answer_t        ans;
        coord[0] = pt.x;
        coord[1] = pt.y;
        coord[2] = pt.z;
        ans.in_box = 1'b1;
        for (int c = 0; c < 3; c++) begin
            ctr    = $signed(box_reg[REG_CENTER][16*c +: 16]);
            ofs[c] = coord[c] - ctr;
            acc[c] = ctr <<< OUT_SH;
        end
        for (int a = 0; a < 3; a++) begin
            // a negative half extent counts as zero
            lim = $signed(box_reg[REG_HALF][16*a +: 16]);
            if (lim < 0) lim = 0;
            lim  = lim <<< PROJ_SH;
            proj = 0;
            for (int c = 0; c < 3; c++) begin
                comp[c] = $signed(box_reg[AXIS_REG[a]][16*c +: 16]);
                proj    = proj + ofs[c] * comp[c];
            end
            if (proj > lim || proj < -lim) ans.in_box = 1'b0;
            if (proj > lim) proj = lim;
            else if (proj < -lim) proj = -lim;
            for (int c = 0; c < 3; c++) acc[c] = acc[c] + comp[c] * proj;
        end
        // round half up to Q8.8, then saturate
        for (int c = 0; c < 3; c++) begin
            rnd = (acc[c] + (64'sd1 <<< (OUT_SH - 1))) >>> OUT_SH;
            if (rnd > 32767) rnd = 32767;
            else if (rnd < -32768) rnd = -32768;
            coord[c] = rnd[15:0];
        end
        ans.x = coord[0];
        ans.y = coord[1];
        ans.z = coord[2];
        return ans;
    endfunction

    task automatic check_field(input string what, input logic signed [15:0] want,
                               input logic signed [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // Sample both handshakes, predict on input, check on output, mirror writes
    always @(posedge aclk) begin
        box_answer_t want;
        if (!aresetn) begin
            in_taken             <= 1'b0;
            box_reg[REG_AXIS_U]  <= AXIS_U_RST;
            box_reg[REG_AXIS_V]  <= AXIS_V_RST;
            box_reg[REG_AXIS_W]  <= AXIS_W_RST;
            box_reg[REG_CENTER]  <= CENTER_RST;
            box_reg[REG_HALF]    <= HALF_RST;
        end else begin
            in_taken <= s_valid && s_ready;
            if (s_valid && s_ready)
                answer_due_q.push_back(query_box({s_point_x, s_point_y, s_point_z}));
            if (m_valid && m_ready) begin
                if (answer_due_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d",
                             $time, m_inside_res, m_closest_x, m_closest_y, m_closest_z);
                    mismatch_count++;
                end else begin
                    want = answer_due_q.pop_front();
                    check_field("inside", 16'(want.in_box), 16'(m_inside_res));
                    check_field("closest_x", want.x, m_closest_x);
                    check_field("closest_y", want.y, m_closest_y);
                    check_field("closest_z", want.z, m_closest_z);
                end
            end
            if (cfg_wr_en && cfg_index <= REG_HALF) box_reg[cfg_index] <= cfg_wdata;
        end
    end

    // Present the next point once the current one is taken, idling at random
    always @(negedge aclk) begin
        point_t nxt;
        if (aresetn && !(s_valid && !in_taken)) begin
            if (point_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                nxt = point_q.pop_front();
                s_valid   <= 1'b1;
                s_point_x <= nxt.x;
                s_point_y <= nxt.y;
                s_point_z <= nxt.z;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random
    always @(negedge aclk) begin
        if (aresetn) m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Guard against a hang
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("obb_point_containment_closest_unit verification failed");
            $finish;
        end
    end

    task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_point(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z);
        point_q.push_back({x, y, z});
    endtask

    // Wait for every point to go in and every answer to come back
    task automatic drain();
        while (point_q.size() != 0 || s_valid || answer_due_q.size() != 0) @(posedge aclk);
        repeat (LATENCY_PAD) @(posedge aclk);
    endtask

    function automatic logic [REG_W-1:0] rand48();
        logic [REG_W-1:0] v;
        for (int c = 0; c < 3; c++) v[16*c +: 16] = 16'($urandom_range(0, 65535));
        return v;
    endfunction

    // Load a random box: mostly near-unit axes and modest extents, some wild
    task automatic random_box();
        logic [REG_W-1:0] v;
        logic [15:0]      comp;
        int               sel;
        for (int a = 0; a < 3; a++) begin
            for (int c = 0; c < 3; c++) begin
                sel = $urandom_range(0, 9);
                if (sel < 3) comp = 16'($urandom_range(0, 65535));
                else if (sel < 9) comp = 16'($urandom_range(0, 32768) - 16384);
                else comp = '0;
                v[16*c +: 16] = comp;
            end
            set_reg(AXIS_REG[a], v);
        end
        for (int c = 0; c < 3; c++) begin
            if ($urandom_range(0, 1)) comp = 16'($urandom_range(0, 65535));
            else comp = 16'($urandom_range(0, 8192) - 4096);
            v[16*c +: 16] = comp;
        end
        set_reg(REG_CENTER, v);
        for (int c = 0; c < 3; c++) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) comp = 16'($urandom_range(0, 4096));
            else if (sel < 8) comp = 16'($urandom_range(0, 65535));
            else if (sel == 8) comp = 16'h7FFF;
            else comp = '0;
            v[16*c +: 16] = comp;
        end
        set_reg(REG_HALF, v);
    endtask

    // Queue points: most near the centre, some anywhere, a few at the rails
    task automatic queue_random(input int count);
        logic [15:0] p [3];
        int          sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            for (int c = 0; c < 3; c++) begin
                if (sel < 65)
                    p[c] = 16'(box_reg[REG_CENTER][16*c +: 16]
                               + $urandom_range(0, 4096) - 2048);
                else if (sel < 95) p[c] = 16'($urandom_range(0, 65535));
                else p[c] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            end
            queue_point(p[0], p[1], p[2]);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Unit box after reset: origin, faces, just outside, rails, bit patterns
        queue_point(16'h0000, 16'h0000, 16'h0000);
        queue_point(16'h0100, 16'h0000, 16'h0000);
        queue_point(16'h0101, 16'h0000, 16'h0000);
        queue_point(16'hFF00, 16'hFF00, 16'hFF00);
        queue_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_point(16'h8000, 16'h8000, 16'h8000);
        queue_point(16'h7FFF, 16'h8000, 16'h0000);
        queue_point(16'h5555, 16'hAAAA, 16'h00FF);
        queue_point(16'hAAAA, 16'h5555, 16'hFF00);
        drain();

        // Extreme box: most negative and most positive axes, a zero axis,
        // centre and extents at the rails
        set_reg(REG_AXIS_U, 48'h8000_8000_8000);
        set_reg(REG_AXIS_V, 48'h7FFF_7FFF_7FFF);
        set_reg(REG_AXIS_W, 48'h0000_0000_0000);
        set_reg(REG_CENTER, 48'h7FFF_8000_7FFF);
        set_reg(REG_HALF,   48'h7FFF_7FFF_7FFF);
        queue_point(16'h8000, 16'h8000, 16'h8000);
        queue_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_point(16'h7FFF, 16'h8000, 16'h7FFF);
        queue_point(16'h0000, 16'h0000, 16'h0000);
        drain();

        // Negative half extents on u and v: only the centre line is inside
        set_reg(REG_AXIS_U, AXIS_U_RST);
        set_reg(REG_AXIS_V, AXIS_V_RST);
        set_reg(REG_AXIS_W, AXIS_W_RST);
        set_reg(REG_CENTER, 48'h0080_FF00_0100);
        set_reg(REG_HALF,   48'h0100_FFFF_8000);
        queue_point(16'h0100, 16'hFF00, 16'h0080);
        queue_point(16'h0101, 16'hFF00, 16'h0080);
        queue_point(16'h0100, 16'hFF00, 16'h0180);
        queue_point(16'h7FFF, 16'h8000, 16'h7FFF);
        drain();

        // Box turned 45 degrees about z
        set_reg(REG_AXIS_U, 48'h0000_2D41_2D41);
        set_reg(REG_AXIS_V, 48'h0000_2D41_D2BF);
        set_reg(REG_CENTER, 48'h0000_0200_FE00);
        set_reg(REG_HALF,   48'h0080_0100_0200);
        queue_point(16'hFE00, 16'h0200, 16'h0000);
        queue_point(16'h0100, 16'h0500, 16'h0000);
        queue_point(16'hFE80, 16'h0280, 16'h0080);
        queue_point(16'h8000, 16'h7FFF, 16'h0000);
        drain();

        // Writes to unused indexes must leave the box alone
        for (int k = NUM_REGS; k < 2**IDX_W; k++) set_reg(k[IDX_W-1:0], rand48());
        queue_point(16'hFE40, 16'h0240, 16'hFFC0);
        queue_point(16'h1234, 16'hEDCB, 16'h0040);
        drain();

        // Random boxes and points; one phase without idling, one with a
        // full pause of the sender halfway through
        for (int ph = 0; ph < 6; ph++) begin
            random_box();
            steady = (ph == 1);
            if (ph == 3) begin
                queue_random(PHASE_ITEMS / 2);
                drain();
                queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            end else begin
                queue_random(PHASE_ITEMS);
            end
            drain();
            steady = 1'b0;
        end

        if (mismatch_count == 0) begin
            $display("obb_point_containment_closest_unit verification clean");
        end else begin
            $display("obb_point_containment_closest_unit verification failed");
        end
        $finish;
    end

endmodule
